@@ hdl/kfpv_pkg.sv @@
// Shared constants, codes and the saturating clamp of the 1-D position/velocity Kalman filter.
// No dependencies; used by every module of the block.
`default_nettype none

package kfpv_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int VAR_W     = 31;
  localparam int CFG_IDX_W = 3;

  // divider: numerator is |value| << FRAC_BITS, divisor is P00 + R
  localparam int NUM_W  = DATA_W + FRAC_BITS;
  localparam int DEN_W  = VAR_W + 2;
  localparam int REM_W  = DEN_W + 1;
  localparam int CNT_W  = $clog2(NUM_W + 1);

  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = DATA_W + 4;

  localparam logic [VAR_W-1:0] ONE_RST      = VAR_W'(64'd1 << FRAC_BITS);
  localparam logic [VAR_W-1:0] INIT_VAR_RST = VAR_W'(64'd1000 << FRAC_BITS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DT       = 3'd0,
    REG_MEAS_R   = 3'd1,
    REG_Q_POS    = 3'd2,
    REG_Q_VEL    = 3'd3,
    REG_U_POS    = 3'd4,
    REG_U_VEL    = 3'd5,
    REG_INIT_VAR = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_CALC,
    ST_DONE
  } state_e;

  // named after the step's multiply, else its write-back; the previous product retires alongside
  typedef enum logic [3:0] {
    STEP_K0Y,
    STEP_K1Y,
    STEP_K1P01,
    STEP_K0P00,
    STEP_K0P01,
    STEP_DTP11,
    STEP_DTP01,
    STEP_DTP01N,
    STEP_DTVEL,
    STEP_POS,
    STEP_P11,
    STEP_VEL
  } step_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     sat;
  } sat_t;

  // clamp to the signed word range, or to [0, 2^31-1] for variances
  function automatic sat_t clamp(input logic signed [PROD_W-1:0] v, input logic var_mode);
    sat_t                     r;
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = {{(PROD_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    lo = var_mode ? '0 : {{(PROD_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
    if (v > hi) begin
      r.val = hi[DATA_W-1:0];
      r.sat = 1'b1;
    end else if (v < lo) begin
      r.val = lo[DATA_W-1:0];
      r.sat = 1'b1;
    end else begin
      r.val = v[DATA_W-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/kfpv_div.sv @@
// Radix-2 restoring divider: two numerators over one shared divisor, one quotient bit a cycle.
// Depends on kfpv_pkg for widths.
`default_nettype none

module kfpv_div import kfpv_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num0_i,
  input  wire logic [NUM_W-1:0] num1_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic      [NUM_W-1:0] quo0_o,
  output logic      [NUM_W-1:0] quo1_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] n0_q, n0_d, n1_q, n1_d;
  logic [REM_W-1:0] r0_q, r0_d, r1_q, r1_d;
  logic [DEN_W-1:0] den_q, den_d;

  logic [REM_W-1:0] t0, t1, dext;
  logic             ge0, ge1;

  assign dext = {1'b0, den_q};
  assign t0   = {r0_q[REM_W-2:0], n0_q[NUM_W-1]};
  assign t1   = {r1_q[REM_W-2:0], n1_q[NUM_W-1]};
  assign ge0  = (t0 >= dext);
  assign ge1  = (t1 >= dext);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    n0_d   = n0_q;
    n1_d   = n1_q;
    r0_d   = r0_q;
    r1_d   = r1_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W);
      n0_d   = num0_i;
      n1_d   = num1_i;
      r0_d   = '0;
      r1_d   = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      r0_d  = ge0 ? (t0 - dext) : t0;
      r1_d  = ge1 ? (t1 - dext) : t1;
      n0_d  = {n0_q[NUM_W-2:0], ge0};
      n1_d  = {n1_q[NUM_W-2:0], ge1};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n0_q  <= n0_d;
    n1_q  <= n1_d;
    r0_q  <= r0_d;
    r1_q  <= r1_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo0_o = n0_q;
  assign quo1_o = n1_q;

endmodule

`default_nettype wire

@@ hdl/kalman_filter_pos_vel_1d.sv @@
// Sequence from accepting a measurement word to result valid: a divider pass for both gains,
// loading them, then 12 shared multiplier and adder steps; when P00 + R is zero the update
// is skipped and only the steps from STEP_DTP11 on are run.
// One word at a time: the next word is taken only once the result leaves.
// Reset (async, active low): state zero, P00 = P11 = 1000.0, registers at their defaults.
// Depends on kfpv_pkg and kfpv_div.
`default_nettype none

module kalman_filter_pos_vel_1d import kfpv_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic     [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic        [DATA_W-1:0] cfg_wdata_i,
  input  wire logic                     meas_valid_i,
  output logic                          meas_stall_o,
  input  wire logic signed [DATA_W-1:0] meas_value_i,
  output logic                          res_valid_o,
  input  wire logic                     res_stall_i,
  output logic signed      [DATA_W-1:0] pos_est_o,
  output logic signed      [DATA_W-1:0] vel_est_o,
  output logic              [VAR_W-1:0] var_pos_o,
  output logic signed      [DATA_W-1:0] cov_pos_vel_o,
  output logic              [VAR_W-1:0] var_vel_o,
  output logic                          saturated_o
);

  // configuration
  logic        [VAR_W-1:0]  dt_q, r_q, q00_q, q11_q;
  logic signed [DATA_W-1:0] u0_q, u1_q;

  // control
  state_e state_q, state_d;
  step_e  step_q, step_d;
  logic   skip_q, skip_d;
  logic   flag_q, flag_d;

  // filter state and working registers
  logic signed [DATA_W-1:0] pos_q, pos_d, vel_q, vel_d;
  logic signed [DATA_W-1:0] p00_q, p00_d, p01_q, p01_d, p11_q, p11_d;
  logic signed [DATA_W-1:0] z_q, z_d, y_q, y_d, k0_q, k0_d, k1_q, k1_d;
  logic signed [DATA_W-1:0] m1_q, m1_d, p01n_q, p01n_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;

  // shared datapath
  logic signed [DATA_W-1:0] ma, mb;
  logic signed [ACC_W-1:0]  opa, opb, opc, opd, sum;
  logic                     var_mode, use_add, use_fm;
  sat_t                     add_res, fm_res, k1_res;

  // divider
  logic                     div_start, div_done;
  logic [NUM_W-1:0]         div_num0, div_num1, div_q0, div_q1;
  logic [DEN_W-1:0]         s_sum;
  logic [DATA_W-1:0]        p01_abs;
  logic signed [PROD_W-1:0] k1_mag;

  function automatic logic signed [ACC_W-1:0] sx(input logic signed [DATA_W-1:0] v);
    return {{(ACC_W-DATA_W){v[DATA_W-1]}}, v};
  endfunction

  function automatic logic signed [ACC_W-1:0] ux(input logic [VAR_W-1:0] v);
    return {{(ACC_W-VAR_W){1'b0}}, v};
  endfunction

  assign s_sum    = {2'b00, p00_q[VAR_W-1:0]} + {2'b00, r_q};
  assign p01_abs  = p01_q[DATA_W-1] ? (~p01_q + DATA_W'(1)) : p01_q;
  assign div_num0 = {{(NUM_W-VAR_W-FRAC_BITS){1'b0}}, p00_q[VAR_W-1:0], {FRAC_BITS{1'b0}}};
  assign div_num1 = {p01_abs, {FRAC_BITS{1'b0}}};

  kfpv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num0_i  (div_num0),
    .num1_i  (div_num1),
    .den_i   (s_sum),
    .done_o  (div_done),
    .quo0_o  (div_q0),
    .quo1_o  (div_q1)
  );

  assign k1_mag = {{(PROD_W-NUM_W){1'b0}}, div_q1};
  assign k1_res = clamp(p01_q[DATA_W-1] ? -k1_mag : k1_mag, 1'b0);

  assign prod_d = ma * mb;
  assign fm_res = clamp(prod_q >>> FRAC_BITS, 1'b0);
  assign sum     = opa + opb + opc + opd;
  assign add_res = clamp({{(PROD_W-ACC_W){sum[ACC_W-1]}}, sum}, var_mode);

  // operand selection for the shared multiplier and adder
  always_comb begin
    ma       = signed'({1'b0, dt_q});
    mb       = vel_q;
    opa      = '0;
    opb      = '0;
    opc      = '0;
    opd      = '0;
    var_mode = 1'b0;
    use_add  = 1'b0;
    use_fm   = 1'b0;
    case (state_q)
      ST_DIV: begin
        opa     = sx(z_q);
        opb     = -sx(pos_q);
        use_add = 1'b1;
      end
      ST_CALC: begin
        case (step_q)
          STEP_K0Y: begin
            ma = k0_q;
            mb = y_q;
          end
          STEP_K1Y: begin
            ma      = k1_q;
            mb      = y_q;
            opa     = sx(pos_q);
            opb     = sx(fm_res.val);
            use_add = 1'b1;
            use_fm  = 1'b1;
          end
          STEP_K1P01: begin
            ma      = k1_q;
            mb      = p01_q;
            opa     = sx(vel_q);
            opb     = sx(fm_res.val);
            use_add = 1'b1;
            use_fm  = 1'b1;
          end
          STEP_K0P00: begin
            ma       = k0_q;
            mb       = p00_q;
            opa      = sx(p11_q);
            opb      = -sx(fm_res.val);
            var_mode = 1'b1;
            use_add  = 1'b1;
            use_fm   = 1'b1;
          end
          STEP_K0P01: begin
            ma       = k0_q;
            mb       = p01_q;
            opa      = sx(p00_q);
            opb      = -sx(fm_res.val);
            var_mode = 1'b1;
            use_add  = 1'b1;
            use_fm   = 1'b1;
          end
          STEP_DTP11: begin
            mb      = p11_q;
            opa     = sx(p01_q);
            opb     = -sx(fm_res.val);
            use_add = !skip_q;
            use_fm  = !skip_q;
          end
          STEP_DTP01: begin
            mb      = p01_q;
            opa     = sx(p01_q);
            opb     = sx(fm_res.val);
            use_add = 1'b1;
            use_fm  = 1'b1;
          end
          STEP_DTP01N: begin
            mb     = p01n_q;
            use_fm = 1'b1;
          end
          STEP_DTVEL: begin
            mb       = vel_q;
            opa      = sx(p00_q);
            opb      = sx(m1_q);
            opc      = sx(fm_res.val);
            opd      = ux(q00_q);
            var_mode = 1'b1;
            use_add  = 1'b1;
            use_fm   = 1'b1;
          end
          STEP_POS: begin
            opa     = sx(pos_q);
            opb     = sx(fm_res.val);
            opc     = sx(u0_q);
            use_add = 1'b1;
            use_fm  = 1'b1;
          end
          STEP_P11: begin
            opa      = sx(p11_q);
            opb      = ux(q11_q);
            var_mode = 1'b1;
            use_add  = 1'b1;
          end
          STEP_VEL: begin
            opa     = sx(vel_q);
            opb     = sx(u1_q);
            use_add = 1'b1;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // sequencer and write-back
  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    skip_d    = skip_q;
    flag_d    = flag_q | (use_add & add_res.sat) | (use_fm & fm_res.sat);
    div_start = 1'b0;
    pos_d     = pos_q;
    vel_d     = vel_q;
    p00_d     = p00_q;
    p01_d     = p01_q;
    p11_d     = p11_q;
    z_d       = z_q;
    y_d       = y_q;
    k0_d      = k0_q;
    k1_d      = k1_q;
    m1_d      = m1_q;
    p01n_d    = p01n_q;
    case (state_q)
      ST_IDLE: begin
        if (meas_valid_i) begin
          z_d = meas_value_i;
          if (s_sum == '0) begin
            skip_d  = 1'b1;
            flag_d  = 1'b1;
            step_d  = STEP_DTP11;
            state_d = ST_CALC;
          end else begin
            skip_d    = 1'b0;
            flag_d    = 1'b0;
            div_start = 1'b1;
            state_d   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        y_d = add_res.val;
        if (div_done) begin
          k0_d    = div_q0[DATA_W-1:0];
          k1_d    = k1_res.val;
          flag_d  = flag_q | add_res.sat | k1_res.sat;
          step_d  = STEP_K0Y;
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        step_d = step_e'(step_q + 4'd1);
        case (step_q)
          STEP_K1Y:    pos_d  = add_res.val;
          STEP_K1P01:  vel_d  = add_res.val;
          STEP_K0P00:  p11_d  = add_res.val;
          STEP_K0P01:  p00_d  = add_res.val;
          STEP_DTP11: begin
            if (!skip_q) begin
              p01_d = add_res.val;
            end
          end
          STEP_DTP01:  p01n_d = add_res.val;
          STEP_DTP01N: m1_d   = fm_res.val;
          STEP_DTVEL:  p00_d  = add_res.val;
          STEP_POS:    pos_d  = add_res.val;
          STEP_P11:    p11_d  = add_res.val;
          STEP_VEL: begin
            vel_d   = add_res.val;
            p01_d   = p01n_q;
            state_d = ST_DONE;
          end
          default: begin
          end
        endcase
      end
      ST_DONE: begin
        if (!res_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= STEP_K0Y;
      skip_q  <= 1'b0;
      flag_q  <= 1'b0;
      pos_q   <= '0;
      vel_q   <= '0;
      p00_q   <= signed'({1'b0, INIT_VAR_RST});
      p01_q   <= '0;
      p11_q   <= signed'({1'b0, INIT_VAR_RST});
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      skip_q  <= skip_d;
      flag_q  <= flag_d;
      pos_q   <= pos_d;
      vel_q   <= vel_d;
      p00_q   <= p00_d;
      p01_q   <= p01_d;
      p11_q   <= p11_d;
    end
  end

  always_ff @(posedge clk_i) begin
    z_q    <= z_d;
    y_q    <= y_d;
    k0_q   <= k0_d;
    k1_q   <= k1_d;
    m1_q   <= m1_d;
    p01n_q <= p01n_d;
    prod_q <= prod_d;
  end

  // init_variance only matters at reset, which also restores its default: no storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q  <= ONE_RST;
      r_q   <= ONE_RST;
      q00_q <= '0;
      q11_q <= '0;
      u0_q  <= '0;
      u1_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_DT:       dt_q  <= cfg_wdata_i[VAR_W-1:0];
        REG_MEAS_R:   r_q   <= cfg_wdata_i[VAR_W-1:0];
        REG_Q_POS:    q00_q <= cfg_wdata_i[VAR_W-1:0];
        REG_Q_VEL:    q11_q <= cfg_wdata_i[VAR_W-1:0];
        REG_U_POS:    u0_q  <= signed'(cfg_wdata_i);
        REG_U_VEL:    u1_q  <= signed'(cfg_wdata_i);
        REG_INIT_VAR: ;
        default: ;
      endcase
    end
  end

  assign meas_stall_o  = (state_q != ST_IDLE);
  assign res_valid_o   = (state_q == ST_DONE);
  assign pos_est_o     = pos_q;
  assign vel_est_o     = vel_q;
  assign var_pos_o     = p00_q[VAR_W-1:0];
  assign cov_pos_vel_o = p01_q;
  assign var_vel_o     = p11_q[VAR_W-1:0];
  assign saturated_o   = flag_q;

endmodule

`default_nettype wire

@@ hdl/kfpv_check.sv @@
// Port-level checks on the Kalman filter top level, bound to every instance.
// Depends on kfpv_pkg for widths.
`default_nettype none

module kfpv_check import kfpv_pkg::*; (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     meas_valid_i,
  input wire logic                     meas_stall_o,
  input wire logic                     res_valid_o,
  input wire logic                     res_stall_i,
  input wire logic signed [DATA_W-1:0] pos_est_o,
  input wire logic signed [DATA_W-1:0] vel_est_o,
  input wire logic         [VAR_W-1:0] var_pos_o,
  input wire logic signed [DATA_W-1:0] cov_pos_vel_o,
  input wire logic         [VAR_W-1:0] var_vel_o,
  input wire logic                     saturated_o
);

  // a word taken is still in flight on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    meas_valid_i && !meas_stall_o |=> meas_stall_o && !res_valid_o)
    else $error("result or ready too early after accepted word");

  // no new word while a result waits
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> meas_stall_o)
    else $error("input ready while result pending");

  // a result is not repeated once it has been taken
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_stall_i |=> !res_valid_o)
    else $error("result repeated");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_stall_i |=> res_valid_o && $stable(pos_est_o) && $stable(vel_est_o)
      && $stable(var_pos_o) && $stable(cov_pos_vel_o) && $stable(var_vel_o)
      && $stable(saturated_o))
    else $error("stalled result changed");

endmodule

bind kalman_filter_pos_vel_1d kfpv_check u_kfpv_check (.*);

`default_nettype wire
